// ===== hdl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal line editor package
// Shared constants, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int DEFAULT_RING_SIZE = 128;
  localparam int ERASE_W           = 7;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ETB = 8'h17;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic       OP_RX   = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [3:0] MAX_STREAM = 4'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_NO_LINE = 2'd3;

  // Class of the item held in the datapath.
  typedef enum logic [3:0] {
    CLS_READ_BAD,
    CLS_READ_NO_LINE,
    CLS_READ,
    CLS_BUSY,
    CLS_CR,
    CLS_BACKSPACE,
    CLS_WORD,
    CLS_KILL,
    CLS_CHAR
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_WE_REQ,
    S_WE_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_issue;
    logic rd_finish;
    logic we_issue;
    logic we_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    cls_t kind;
    logic len_zero;
    logic white;
    logic out_full;
  } sts_t;

endpackage

// ===== hdl/tle_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one received byte or read request.
// ----------------------------------------------------------------------------
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] stream_id;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output stream_id, output rx_byte,
                  input ready);
  modport sink (input valid, input opcode, input stream_id, input rx_byte,
                output ready);
endinterface

// ===== hdl/tle_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result per accepted item.
// ----------------------------------------------------------------------------
interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] echo_count;
  logic [7:0] echo_first;
  logic [7:0] echo_second;
  logic [6:0] erase_count;
  logic [7:0] read_byte;
  logic       last_of_line;

  modport source (output valid, output status, output echo_count,
                  output echo_first, output echo_second, output erase_count,
                  output read_byte, output last_of_line, input ready);
  modport sink (input valid, input status, input echo_count, input echo_first,
                input echo_second, input erase_count, input read_byte,
                input last_of_line, output ready);
endinterface

// ===== hdl/terminal_line_editor_top.sv =====
// Sequence: each item is accepted, decoded and handed over to the output
// register; a read request adds a wait for the registered read of the line
// memory, and a word erase checks one character per memory read before the
// hand-over. A new item is accepted only after the last one is handed over,
// and the hand-over waits while the output register is occupied.
// Reset (rst, synchronous): empty line, editing mode, no result pending; the
// line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Terminal line editor
// Canonical line editing of terminal input with echo and erase reporting,
// and byte-wise reading of a finished line.
// ----------------------------------------------------------------------------
module terminal_line_editor_top #(
  parameter int RING_SIZE = tle_pkg::DEFAULT_RING_SIZE
) (
  input logic       clk,
  input logic       rst,
  tle_in_if.sink    in_ch,
  tle_out_if.source out_ch
);

  tle_pkg::cmd_t cmd;
  tle_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tle_dp #(
    .RING_SIZE (RING_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (in_ch.opcode),
    .stream_id    (in_ch.stream_id),
    .rx_byte      (in_ch.rx_byte),
    .res_valid    (out_ch.valid),
    .res_ready    (out_ch.ready),
    .status       (out_ch.status),
    .echo_count   (out_ch.echo_count),
    .echo_first   (out_ch.echo_first),
    .echo_second  (out_ch.echo_second),
    .erase_count  (out_ch.erase_count),
    .read_byte    (out_ch.read_byte),
    .last_of_line (out_ch.last_of_line)
  );

endmodule

// ===== hdl/tle_ctrl.sv =====
// ----------------------------------------------------------------------------
// Terminal line editor controller
// Sequences capture, decode, memory reads, the word erase walk and the
// hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module tle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);

  tle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = tle_pkg::S_DECODE;
        end
      end
      tle_pkg::S_DECODE: begin
        case (sts.kind)
          tle_pkg::CLS_READ: begin
            cmd.rd_issue = 1'b1;
            state_next   = tle_pkg::S_RD_WAIT;
          end
          tle_pkg::CLS_WORD: begin
            state_next = tle_pkg::S_WE_REQ;
          end
          default: begin
            cmd.exec   = 1'b1;
            state_next = tle_pkg::S_EMIT;
          end
        endcase
      end
      tle_pkg::S_RD_WAIT: begin
        cmd.rd_finish = 1'b1;
        state_next    = tle_pkg::S_EMIT;
      end
      tle_pkg::S_WE_REQ: begin
        if (sts.len_zero) begin
          state_next = tle_pkg::S_EMIT;
        end else begin
          cmd.we_issue = 1'b1;
          state_next   = tle_pkg::S_WE_CHK;
        end
      end
      tle_pkg::S_WE_CHK: begin
        // The character before the cursor is now on the memory read port.
        if (sts.white) begin
          state_next = tle_pkg::S_EMIT;
        end else begin
          cmd.we_step = 1'b1;
          state_next  = tle_pkg::S_WE_REQ;
        end
      end
      tle_pkg::S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = tle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tle_pkg::S_IDLE;
      end
    endcase
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_full)
    else $error("result handed over while the output register is occupied");

  a_capture_decode: assert property (@(posedge clk) disable iff (rst)
    (state == tle_pkg::S_IDLE && in_valid) |=> state == tle_pkg::S_DECODE)
    else $error("accepted item not decoded in the following cycle");

endmodule

// ===== hdl/tle_dp.sv =====
// ----------------------------------------------------------------------------
// Terminal line editor datapath
// Line memory, length and read position, item decode, result assembly and
// the output register.
// ----------------------------------------------------------------------------
module tle_dp #(
  parameter int RING_SIZE = tle_pkg::DEFAULT_RING_SIZE
) (
  input  logic          clk,
  input  logic          rst,
  input  tle_pkg::cmd_t cmd,
  output tle_pkg::sts_t sts,
  input  logic          opcode,
  input  logic [3:0]    stream_id,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [1:0]    status,
  output logic [1:0]    echo_count,
  output logic [7:0]    echo_first,
  output logic [7:0]    echo_second,
  output logic [6:0]    erase_count,
  output logic [7:0]    read_byte,
  output logic          last_of_line
);

  localparam int LW  = $clog2(RING_SIZE);
  localparam int LW1 = LW + 1;
  localparam logic [LW:0] LEN_LIMIT = LW1'(RING_SIZE - 2);

  logic [7:0] mem [RING_SIZE];
  logic [7:0] mem_q;
  logic          mem_we;
  logic [LW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [LW-1:0] mem_raddr;

  logic [LW-1:0] length;
  logic [LW-1:0] read_position;
  logic          line_ready;

  logic       item_opcode;
  logic [3:0] item_stream;
  logic [7:0] item_byte;

  logic [1:0]  res_status;
  logic [1:0]  res_ecount;
  logic [7:0]  res_efirst;
  logic [7:0]  res_esecond;
  logic [6:0]  res_erased;
  logic [7:0]  res_rbyte;
  logic        res_last;

  logic [LW-1:0] len_dec;
  logic [LW:0]   pos_inc;
  logic          line_full;
  tle_pkg::cls_t kind;

  assign len_dec   = length - LW'(1);
  assign pos_inc   = {1'b0, read_position} + LW1'(1);
  assign line_full = {1'b0, length} >= LEN_LIMIT;

  always_comb begin
    if (item_opcode == tle_pkg::OP_READ) begin
      if (item_stream > tle_pkg::MAX_STREAM) begin
        kind = tle_pkg::CLS_READ_BAD;
      end else if (!line_ready) begin
        kind = tle_pkg::CLS_READ_NO_LINE;
      end else begin
        kind = tle_pkg::CLS_READ;
      end
    end else if (line_ready) begin
      kind = tle_pkg::CLS_BUSY;
    end else if (item_byte == tle_pkg::CH_CR) begin
      kind = tle_pkg::CLS_CR;
    end else if (item_byte == tle_pkg::CH_BS || item_byte == tle_pkg::CH_DEL) begin
      kind = tle_pkg::CLS_BACKSPACE;
    end else if (item_byte == tle_pkg::CH_ETB) begin
      kind = tle_pkg::CLS_WORD;
    end else if (item_byte == tle_pkg::CH_NAK) begin
      kind = tle_pkg::CLS_KILL;
    end else begin
      kind = tle_pkg::CLS_CHAR;
    end
  end

  assign sts.kind     = kind;
  assign sts.len_zero = (length == '0);
  assign sts.white    = (mem_q == tle_pkg::CH_SP) ||
                        (mem_q >= tle_pkg::CH_TAB && mem_q <= tle_pkg::CH_CR);
  assign sts.out_full = res_valid && !res_ready;

  // Memory ports: a newline, or a received character byte while the line is not full, is written at the cursor.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = length;
    mem_wdata = item_byte;
    if (cmd.exec && kind == tle_pkg::CLS_CR) begin
      mem_we    = 1'b1;
      mem_wdata = tle_pkg::CH_LF;
    end else if (cmd.exec && kind == tle_pkg::CLS_CHAR && !line_full) begin
      mem_we = 1'b1;
    end
    mem_re    = cmd.rd_issue || cmd.we_issue;
    mem_raddr = cmd.rd_issue ? read_position : len_dec;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_opcode <= opcode;
      item_stream <= stream_id;
      item_byte   <= rx_byte;
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      length        <= '0;
      read_position <= '0;
      line_ready    <= 1'b0;
    end else if (cmd.exec) begin
      case (kind)
        tle_pkg::CLS_CR: begin
          length        <= length + LW'(1);
          read_position <= '0;
          line_ready    <= 1'b1;
        end
        tle_pkg::CLS_BACKSPACE: begin
          if (length != '0) begin
            length <= len_dec;
          end
        end
        tle_pkg::CLS_KILL: begin
          length <= '0;
        end
        tle_pkg::CLS_CHAR: begin
          if (!line_full) begin
            length <= length + LW'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.we_step) begin
      length <= len_dec;
    end else if (cmd.rd_finish) begin
      if (pos_inc >= {1'b0, length}) begin
        line_ready    <= 1'b0;
        length        <= '0;
        read_position <= '0;
      end else begin
        read_position <= pos_inc[LW-1:0];
      end
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status  <= tle_pkg::ST_OK;
      res_ecount  <= 2'd0;
      res_efirst  <= 8'd0;
      res_esecond <= 8'd0;
      res_erased  <= 7'd0;
      res_rbyte   <= 8'd0;
      res_last    <= 1'b0;
    end else if (cmd.exec) begin
      case (kind)
        tle_pkg::CLS_READ_BAD:     res_status <= tle_pkg::ST_BAD;
        tle_pkg::CLS_READ_NO_LINE: res_status <= tle_pkg::ST_NO_LINE;
        tle_pkg::CLS_BUSY:         res_status <= tle_pkg::ST_BUSY;
        tle_pkg::CLS_CR: begin
          res_ecount  <= 2'd2;
          res_efirst  <= tle_pkg::CH_CR;
          res_esecond <= tle_pkg::CH_LF;
        end
        tle_pkg::CLS_BACKSPACE: begin
          if (length == '0) begin
            res_ecount <= 2'd1;
            res_efirst <= tle_pkg::CH_BEL;
          end else begin
            res_erased <= 7'd1;
          end
        end
        tle_pkg::CLS_KILL: begin
          res_erased <= tle_pkg::ERASE_W'(length);
        end
        tle_pkg::CLS_CHAR: begin
          res_ecount <= 2'd1;
          res_efirst <= line_full ? tle_pkg::CH_BEL : item_byte;
        end
        default: begin
        end
      endcase
    end else if (cmd.we_step) begin
      res_erased <= res_erased + 7'd1;
    end else if (cmd.rd_finish) begin
      res_rbyte <= mem_q;
      res_last  <= (pos_inc >= {1'b0, length});
    end
  end

  // Output register: a finished result waits here while the next item starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= res_status;
      echo_count   <= res_ecount;
      echo_first   <= res_efirst;
      echo_second  <= res_esecond;
      erase_count  <= res_erased;
      read_byte    <= res_rbyte;
      last_of_line <= res_last;
    end
  end

  a_ready_has_line: assert property (@(posedge clk) disable iff (rst)
    line_ready |-> length != '0)
    else $error("line marked ready with zero length");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    line_ready |-> read_position < length)
    else $error("read position beyond the end of the ready line");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal line editor testbench
// Drives received bytes and read requests through the input channel, keeps
// its own model of the line being edited and checks every result in order,
// under changing amounts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int ITEMS_PER_PHASE = 475;
  localparam int SETTLE_CYCLES   = 20;
  localparam int REPORT_MAX      = 10;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] echo_count;
    logic [7:0] echo_first;
    logic [7:0] echo_second;
    logic [6:0] erase_count;
    logic [7:0] read_byte;
    logic       last_of_line;
  } tty_reply_t;

  class tty_line_scoreboard;
    localparam int RING = tle_pkg::DEFAULT_RING_SIZE;

    bit [7:0]   line_store [RING];
    int         line_len;
    int         read_pos;
    bit         line_ready;
    tty_reply_t awaited [$];

    int n_taken, n_effective, n_checked, n_mismatch, n_unexpected, n_reported;
    int n_lines, n_read_bytes, n_bells, max_erase;

    function new();
      line_len   = 0;
      read_pos   = 0;
      line_ready = 1'b0;
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == tle_pkg::CH_SP || (c >= tle_pkg::CH_TAB && c <= tle_pkg::CH_CR);
    endfunction

    // Works out the result of one accepted transfer and updates the line.
    function void note_transfer(logic op, logic [3:0] sid, logic [7:0] b);
      tty_reply_t r;
      int         erased;
      int         pos;
      r      = '0;
      erased = 0;
      if (op == tle_pkg::OP_READ) begin
        if (sid > tle_pkg::MAX_STREAM) begin
          r.status = tle_pkg::ST_BAD;
        end else if (!line_ready) begin
          r.status = tle_pkg::ST_NO_LINE;
        end else begin
          pos = read_pos;
          if (pos >= RING) pos = RING - 1;
          r.read_byte = line_store[pos];
          read_pos = pos + 1;
          n_read_bytes++;
          if (read_pos >= line_len) begin
            r.last_of_line = 1'b1;
            line_ready = 1'b0;
            line_len   = 0;
            read_pos   = 0;
            n_lines++;
          end
        end
      end else if (line_ready) begin
        r.status = tle_pkg::ST_BUSY;
      end else if (b == tle_pkg::CH_CR) begin
        if (line_len < RING) begin
          line_store[line_len] = tle_pkg::CH_LF;
          line_len++;
        end
        line_ready    = 1'b1;
        read_pos      = 0;
        r.echo_count  = 2'd2;
        r.echo_first  = tle_pkg::CH_CR;
        r.echo_second = tle_pkg::CH_LF;
      end else if (b == tle_pkg::CH_BS || b == tle_pkg::CH_DEL) begin
        if (line_len == 0) begin
          r.echo_count = 2'd1;
          r.echo_first = tle_pkg::CH_BEL;
          n_bells++;
        end else begin
          line_len--;
          erased = 1;
        end
      end else if (b == tle_pkg::CH_ETB) begin
        while (line_len > 0 && !is_blank(line_store[line_len - 1])) begin
          line_len--;
          erased++;
        end
      end else if (b == tle_pkg::CH_NAK) begin
        erased   = line_len;
        line_len = 0;
      end else if (line_len >= RING - 2) begin
        r.echo_count = 2'd1;
        r.echo_first = tle_pkg::CH_BEL;
        n_bells++;
      end else begin
        line_store[line_len] = b;
        line_len++;
        r.echo_count = 2'd1;
        r.echo_first = b;
      end
      r.erase_count = 7'(erased);
      if (erased > max_erase) max_erase = erased;
      if (r.status != tle_pkg::ST_BUSY) n_effective++;
      n_taken++;
      awaited.push_back(r);
    endfunction

    function void check_reply(tty_reply_t got);
      tty_reply_t want;
      if (awaited.size() == 0) begin
        n_unexpected++;
        if (n_reported < REPORT_MAX)
          $display({"[%0t] result with nothing awaited: ",
                    "st=%0d ec=%0d e1=%h e2=%h er=%0d rb=%h last=%0b"},
                   $realtime, got.status, got.echo_count, got.echo_first, got.echo_second,
                   got.erase_count, got.read_byte, got.last_of_line);
        n_reported++;
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.status !== want.status || got.echo_count !== want.echo_count ||
          got.echo_first !== want.echo_first || got.echo_second !== want.echo_second ||
          got.erase_count !== want.erase_count || got.read_byte !== want.read_byte ||
          got.last_of_line !== want.last_of_line) begin
        n_mismatch++;
        if (n_reported < REPORT_MAX) begin
          $display("[%0t] result %0d differs", $realtime, n_checked);
          $display("  expected st=%0d ec=%0d e1=%h e2=%h er=%0d rb=%h last=%0b",
                   want.status, want.echo_count, want.echo_first, want.echo_second,
                   want.erase_count, want.read_byte, want.last_of_line);
          $display("  actual   st=%0d ec=%0d e1=%h e2=%h er=%0d rb=%h last=%0b",
                   got.status, got.echo_count, got.echo_first, got.echo_second,
                   got.erase_count, got.read_byte, got.last_of_line);
        end
        n_reported++;
      end
    endfunction

    function int failures();
      return n_mismatch + n_unexpected + awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_in_pct;
  int   idle_out_pct;
  int   cycles;
  tty_line_scoreboard sb;

  tle_in_if  in_ch ();
  tle_out_if out_ch ();

  terminal_line_editor_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, sb.awaited.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= idle_out_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_reply({out_ch.status, out_ch.echo_count, out_ch.echo_first,
                      out_ch.echo_second, out_ch.erase_count, out_ch.read_byte,
                      out_ch.last_of_line});
  end

  // Entered and left at a falling edge; valid stays high between back-to-back
  // transfers.
  task automatic send_item(logic op, logic [3:0] sid, logic [7:0] b);
    while ($urandom_range(99, 0) < idle_in_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.opcode    = op;
    in_ch.stream_id = sid;
    in_ch.rx_byte   = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_transfer(op, sid, b);
    @(negedge clk);
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item(tle_pkg::OP_RX, 4'($urandom_range(15, 0)), b);
  endtask

  task automatic send_read(logic [3:0] sid);
    send_item(tle_pkg::OP_READ, sid, 8'($urandom_range(255, 0)));
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  function automatic logic [3:0] pick_stream();
    if ($urandom_range(99, 0) < 85) return 4'($urandom_range(2, 0));
    return 4'($urandom_range(15, 3));
  endfunction

  function automatic logic [7:0] pick_char();
    int roll;
    int w;
    roll = $urandom_range(99, 0);
    w    = $urandom_range(4, 0);
    if (roll < 70) return 8'($urandom_range(8'h7E, 8'h21));
    if (roll < 80) return (w == 0) ? tle_pkg::CH_SP : 8'(8 + w);
    if (roll < 88) return $urandom_range(1, 0) ? tle_pkg::CH_BS : tle_pkg::CH_DEL;
    if (roll < 92) return tle_pkg::CH_ETB;
    if (roll < 94) return tle_pkg::CH_NAK;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic run_directed();
    send_read(4'd0);
    send_read(4'd15);
    send_read(4'd3);
    send_rx(tle_pkg::CH_BS);
    send_rx(tle_pkg::CH_DEL);
    send_rx(tle_pkg::CH_ETB);
    send_rx(tle_pkg::CH_NAK);
    send_rx(8'h61);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(tle_pkg::CH_SP);
    // A word erase straight after whitespace removes nothing.
    send_rx(tle_pkg::CH_ETB);
    send_rx(8'h62);
    send_rx(8'h0E);
    send_rx(tle_pkg::CH_ETB);
    send_rx(tle_pkg::CH_DEL);
    send_rx(tle_pkg::CH_BS);
    send_rx(tle_pkg::CH_NAK);
    send_rx(8'h78);
    send_rx(tle_pkg::CH_CR);
    send_rx(8'h79);
    send_read(4'd2);
    send_read(4'd15);
    send_read(4'd1);
    send_rx(tle_pkg::CH_CR);
    send_read(4'd0);
  endtask

  // One edited line, its carriage return and the reads that empty it again.
  task automatic type_line();
    int n;
    if ($urandom_range(99, 0) < 8) begin
      // May run past the full-line limit, so the characters beyond it ring the bell.
      n = $urandom_range(132, 118);
      repeat (n) send_rx(8'($urandom_range(8'h7E, 8'h21)));
      case ($urandom_range(2, 0))
        0: send_rx(tle_pkg::CH_ETB);
        1: send_rx(tle_pkg::CH_NAK);
        default: ;
      endcase
    end else begin
      n = $urandom_range(20, 0);
      repeat (n) send_rx(pick_char());
    end
    if ($urandom_range(7, 0) == 0) send_read(4'($urandom_range(15, 0)));
    send_rx(tle_pkg::CH_CR);
    while (sb.line_ready) begin
      if ($urandom_range(9, 0) == 0) send_rx(8'($urandom_range(255, 0)));
      else send_read(pick_stream());
    end
  endtask

  task automatic run_phase(int in_pct, int out_pct, int target);
    int start;
    idle_in_pct  = in_pct;
    idle_out_pct = out_pct;
    start        = sb.n_effective;
    while (sb.n_effective - start < target) type_line();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = tle_pkg::OP_RX;
    in_ch.stream_id = '0;
    in_ch.rx_byte   = '0;
    rst             = 1'b1;
    idle_in_pct     = 32;
    idle_out_pct    = 88;
    cycles          = 0;
    sb              = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_phase(32, 88, ITEMS_PER_PHASE);
    // Let the editor empty completely before the idling pattern changes.
    wait_drained();
    run_phase(88, 32, ITEMS_PER_PHASE);
    wait_drained();
    run_phase(0, 0, ITEMS_PER_PHASE);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Input transfers: %0d (%0d not ignored), results checked: %0d.",
             sb.n_taken, sb.n_effective, sb.n_checked);
    $display("Lines read out: %0d (%0d bytes), bells: %0d, widest erase: %0d positions.",
             sb.n_lines, sb.n_read_bytes, sb.n_bells, sb.max_erase);
    if (sb.failures() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
